### hdl/dnsab_pkg.sv
`timescale 1ns / 1ps
// Package for the DNS A-record answer builder: limits, fixed packet fields,
// the word phase codes and the structs passed between the RAM, the word
// formatter and the top level. Depends on nothing.
package dnsab_pkg;

   localparam int MAX_LABEL_CHARS = 63;
   localparam int MAX_NAME_CHARS  = 255;

   localparam int RAM_DEPTH  = 16;
   localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);

   localparam logic [7:0]  DOT_CHAR      = 8'h2E;
   localparam logic [15:0] HDR_FLAGS     = 16'h8180;
   localparam logic [15:0] HDR_ONE       = 16'h0001;
   localparam logic [15:0] ANS_POINTER   = 16'hC00C;
   localparam logic [15:0] ANS_RDLENGTH  = 16'h0004;
   localparam logic [15:0] FIELD_ZERO    = 16'h0000;
   localparam logic [8:0]  HDR_BYTES     = 9'd12;
   localparam logic [8:0]  TAIL_BYTES    = 9'd21;

   typedef enum logic [1:0] {
      PH_HDR,
      PH_LABEL,
      PH_TAIL
   } phase_type;

   typedef struct packed {
      logic                  en;
      logic [RAM_ADDR_W-1:0] addr;
      logic [1:0]            lane;
      logic [7:0]            data;
   } ram_wr_type;

   typedef struct packed {
      phase_type             phase;
      logic [3:0]            idx;
      logic [15:0]           query_id;
      logic [31:0]           answer_ip;
      logic [5:0]            label_len;
      logic [3:0][7:0]       ram_word;
   } fmt_req_type;

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  vbytes;
      logic        group_last;
   } fmt_word_type;

endpackage

### hdl/dns_a_answer_builder_unit.sv
`timescale 1ns / 1ps
// DNS A-record answer builder: top level with the sequencer and the output
// register. Instantiates dnsab_label_ram and dnsab_word_format; uses dnsab_pkg.
//
// Usage: a domain name arrives one character per req_ beat, req_name_end
// high on its final character. The query id is taken on the first character
// and the address on the last. The answer packet leaves on the rsp_ channel
// as left-aligned 32-bit words; rsp_packet_end, rsp_packet_length and
// rsp_truncated qualify the final word.
// Sequencing: an ordinary character produces no words. The first character
// also produces the three header words. A dot or the end of the name that
// flushes a label of L characters produces (L + 4) / 4 words: a RAM read
// state, then one word per cycle from the label RAM while rsp_ does not
// stall. The final character also produces the six tail words.
// req_stall is high while words are still being produced. A stall on rsp_
// holds the output register and the sequencer; a new character is still
// taken while a finished word waits. Reset clears the sequencer and the name
// state; the label RAM needs no clearing pass.
module dns_a_answer_builder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_name_char,
   input  logic        req_name_end,
   input  logic [15:0] req_query_id,
   input  logic [31:0] req_answer_ip,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_packet_word,
   output logic [2:0]  rsp_valid_bytes,
   output logic        rsp_packet_end,
   output logic [8:0]  rsp_packet_length,
   output logic        rsp_truncated
);
   import dnsab_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HDR,
      S_FL_RD,
      S_FL_WR,
      S_TAIL
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] idx_ff, idx_in;
   logic       inside_ff, inside_in;
   logic [5:0] label_count_ff, label_count_in;
   logic [7:0] name_count_ff, name_count_in;
   logic       cut_ff, cut_in;
   logic [8:0] total_ff, total_in;
   logic [5:0] flush_len_ff, flush_len_in;
   logic       flush_pend_ff, flush_pend_in;
   logic       tail_pend_ff, tail_pend_in;
   logic [15:0] id_ff, id_in;
   logic [31:0] ip_ff, ip_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [2:0]  rsp_vb_ff, rsp_vb_in;
   logic        rsp_end_ff, rsp_end_in;
   logic [8:0]  rsp_len_ff, rsp_len_in;
   logic        rsp_cut_ff, rsp_cut_in;

   logic        accept;
   logic        out_free;
   logic        emit;
   logic        load;
   logic        hdr;
   logic        is_dot;
   logic [5:0]  lc_base;
   logic [7:0]  nc_base;
   logic [5:0]  lc_after;
   logic [5:0]  store_idx;
   logic [5:0]  flen;
   logic        final_word;

   ram_wr_type             ram_wr;
   logic [RAM_ADDR_W-1:0]  rd_addr;
   logic [3:0][7:0]        ram_word;
   fmt_req_type            fmt_req;
   fmt_word_type           fmt_word;

   dnsab_label_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (ram_word)
   );

   dnsab_word_format u_fmt (
      .req  (fmt_req),
      .word (fmt_word)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = state_ff inside {S_HDR, S_FL_WR, S_TAIL};
   assign load      = emit && out_free;
   assign final_word = (state_ff == S_TAIL) && fmt_word.group_last;

   always_comb begin
      fmt_req.idx       = idx_ff;
      fmt_req.query_id  = id_ff;
      fmt_req.answer_ip = ip_ff;
      fmt_req.label_len = flush_len_ff;
      fmt_req.ram_word  = ram_word;
      case (state_ff)
         S_HDR:   fmt_req.phase = PH_HDR;
         S_TAIL:  fmt_req.phase = PH_TAIL;
         default: fmt_req.phase = PH_LABEL;
      endcase
   end

   assign rd_addr = ((state_ff == S_FL_WR) && load) ? RAM_ADDR_W'(idx_ff + 4'd1)
                                                    : RAM_ADDR_W'(idx_ff);

   always_comb begin
      hdr       = !inside_ff;
      is_dot    = (req_name_char == DOT_CHAR);
      lc_base   = hdr ? 6'd0 : label_count_ff;
      nc_base   = hdr ? 8'd0 : name_count_ff;
      store_idx = lc_base + 6'd1;

      inside_in      = inside_ff;
      label_count_in = label_count_ff;
      name_count_in  = name_count_ff;
      cut_in         = cut_ff;
      total_in       = total_ff;
      flush_len_in   = flush_len_ff;
      flush_pend_in  = flush_pend_ff;
      tail_pend_in   = tail_pend_ff;
      id_in          = id_ff;
      ip_in          = ip_ff;
      lc_after       = lc_base;
      flen           = 6'd0;

      ram_wr.en   = 1'b0;
      ram_wr.addr = store_idx[5:2];
      ram_wr.lane = store_idx[1:0];
      ram_wr.data = req_name_char;

      if (accept) begin
         cut_in        = hdr ? 1'b0 : cut_ff;
         name_count_in = nc_base;
         if (nc_base < 8'(MAX_NAME_CHARS)) begin
            name_count_in = nc_base + 8'd1;
            if (is_dot) begin
               flen     = lc_base;
               lc_after = 6'd0;
            end else if (lc_base < 6'(MAX_LABEL_CHARS)) begin
               ram_wr.en = 1'b1;
               lc_after  = store_idx;
            end else begin
               cut_in = 1'b1;
            end
         end else begin
            cut_in = 1'b1;
         end
         if (req_name_end) begin
            flen     = (flen != 6'd0) ? flen : lc_after;
            lc_after = 6'd0;
         end
         label_count_in = lc_after;
         inside_in      = !req_name_end;
         flush_len_in   = flen;
         flush_pend_in  = (flen != 6'd0);
         tail_pend_in   = req_name_end;
         total_in       = (hdr ? HDR_BYTES : total_ff)
                          + {3'b000, flen} + {8'h00, (flen != 6'd0)}
                          + (req_name_end ? TAIL_BYTES : 9'd0);
         if (hdr) begin
            id_in = req_query_id;
         end
         ip_in = req_answer_ip;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         S_IDLE: begin
            idx_in = 4'd0;
            if (accept) begin
               if (hdr) begin
                  state_in = S_HDR;
               end else if (flush_pend_in) begin
                  state_in = S_FL_RD;
               end else if (tail_pend_in) begin
                  state_in = S_TAIL;
               end
            end
         end
         S_HDR: begin
            if (load) begin
               idx_in = idx_ff + 4'd1;
               if (fmt_word.group_last) begin
                  idx_in = 4'd0;
                  if (flush_pend_ff) begin
                     state_in = S_FL_RD;
                  end else if (tail_pend_ff) begin
                     state_in = S_TAIL;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_FL_RD: begin
            state_in = S_FL_WR;
         end
         S_FL_WR: begin
            if (load) begin
               idx_in = idx_ff + 4'd1;
               if (fmt_word.group_last) begin
                  idx_in   = 4'd0;
                  state_in = tail_pend_ff ? S_TAIL : S_IDLE;
               end
            end
         end
         S_TAIL: begin
            if (load) begin
               idx_in = idx_ff + 4'd1;
               if (fmt_word.group_last) begin
                  idx_in   = 4'd0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
            idx_in   = 4'd0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rsp_vb_in    = rsp_vb_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_cut_in   = rsp_cut_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = fmt_word.data;
         rsp_vb_in    = fmt_word.vbytes;
         rsp_end_in   = final_word;
         rsp_len_in   = final_word ? total_ff : 9'd0;
         rsp_cut_in   = final_word && cut_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         idx_ff         <= 4'd0;
         inside_ff      <= 1'b0;
         label_count_ff <= 6'd0;
         name_count_ff  <= 8'd0;
         cut_ff         <= 1'b0;
         total_ff       <= 9'd0;
         flush_pend_ff  <= 1'b0;
         tail_pend_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         inside_ff      <= inside_in;
         label_count_ff <= label_count_in;
         name_count_ff  <= name_count_in;
         cut_ff         <= cut_in;
         total_ff       <= total_in;
         flush_pend_ff  <= flush_pend_in;
         tail_pend_ff   <= tail_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      flush_len_ff <= flush_len_in;
      id_ff        <= id_in;
      ip_ff        <= ip_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_vb_ff    <= rsp_vb_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_cut_ff   <= rsp_cut_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packet_word   = rsp_word_ff;
   assign rsp_valid_bytes   = rsp_vb_ff;
   assign rsp_packet_end    = rsp_end_ff;
   assign rsp_packet_length = rsp_len_ff;
   assign rsp_truncated     = rsp_cut_ff;

endmodule

### hdl/dnsab_label_ram.sv
`timescale 1ns / 1ps
// Label buffer: word-wide RAM with byte-lane writes and a registered read.
// Depends on dnsab_pkg for the depth and the write struct.
module dnsab_label_ram (
   input  logic                            clock,
   input  dnsab_pkg::ram_wr_type           wr,
   input  logic [dnsab_pkg::RAM_ADDR_W-1:0] rd_addr,
   output logic [3:0][7:0]                 rd_data
);
   import dnsab_pkg::*;

   logic [3:0][7:0] mem_ff [RAM_DEPTH];
   logic [3:0][7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr][wr.lane] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/dnsab_word_format.sv
`timescale 1ns / 1ps
// Word formatter: builds one output word of the header, a label flush or
// the answer tail from the phase, word index and RAM data. Uses dnsab_pkg.
module dnsab_word_format (
   input  dnsab_pkg::fmt_req_type  req,
   output dnsab_pkg::fmt_word_type word
);
   import dnsab_pkg::*;

   logic [2:0]      lbl_vb;
   logic            lbl_last;
   logic [3:0][7:0] lbl_bytes;

   always_comb begin
      lbl_last = (req.idx == req.label_len[5:2]);
      lbl_vb   = lbl_last ? ({1'b0, req.label_len[1:0]} + 3'd1) : 3'd4;
      for (int k = 0; k < 4; k++) begin
         lbl_bytes[3-k] = (3'(k) < lbl_vb) ? req.ram_word[k] : 8'h00;
      end
      if (req.idx == 4'd0) begin
         lbl_bytes[3] = {2'b00, req.label_len};
      end
   end

   always_comb begin
      word.data       = 32'h0;
      word.vbytes     = 3'd4;
      word.group_last = 1'b0;
      case (req.phase)
         PH_HDR: begin
            case (req.idx)
               4'd0:    word.data = {req.query_id, HDR_FLAGS};
               4'd1:    word.data = {HDR_ONE, HDR_ONE};
               default: begin
                  word.data       = {FIELD_ZERO, FIELD_ZERO};
                  word.group_last = 1'b1;
               end
            endcase
         end
         PH_LABEL: begin
            word.data       = lbl_bytes;
            word.vbytes     = lbl_vb;
            word.group_last = lbl_last;
         end
         PH_TAIL: begin
            case (req.idx)
               4'd0:    word.data = {8'h00, HDR_ONE, 8'h00};
               4'd1:    word.data = {HDR_ONE[7:0], ANS_POINTER, 8'h00};
               4'd2:    word.data = {HDR_ONE[7:0], HDR_ONE, 8'h00};
               4'd3:    word.data = {FIELD_ZERO[7:0], FIELD_ZERO, 8'h00};
               4'd4:    word.data = {ANS_RDLENGTH[7:0], req.answer_ip[31:8]};
               default: begin
                  word.data       = {req.answer_ip[7:0], 24'h0};
                  word.vbytes     = 3'd1;
                  word.group_last = 1'b1;
               end
            endcase
         end
         default: begin
            word.data = 32'h0;
         end
      endcase
   end

endmodule

### test/dnsab_answer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the DNS A-record answer builder. It predicts the answer words
// from each accepted req_ beat and compares every rsp_ beat with them in order.
// Depends on dnsab_pkg for the limits and the fixed packet fields.
module dnsab_answer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_name_char,
   input  logic        req_name_end,
   input  logic [15:0] req_query_id,
   input  logic [31:0] req_answer_ip,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_packet_word,
   input  logic [2:0]  rsp_valid_bytes,
   input  logic        rsp_packet_end,
   input  logic [8:0]  rsp_packet_length,
   input  logic        rsp_truncated,
   output int          words_owed,
   output int          fail_count
);
   import dnsab_pkg::*;

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        last;
      logic [8:0]  total;
      logic        cut;
   } packet_word_type;

   packet_word_type answer_words[$];
   logic [7:0]   group_bytes [0:63];
   logic [7:0]   label_buf [0:MAX_LABEL_CHARS-1];
   int           label_len;
   int           name_len;
   logic         in_name;
   logic         cut_seen;
   logic [8:0]   byte_total;
   int           word_index;

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("checker: word %0d %s expected %h got %h", word_index, what, want, got);
      fail_count++;
   endtask

   task automatic queue_group(input int n);
      packet_word_type w;
      int           pos;
      pos = 0;
      while (pos < n) begin
         w = '0;
         for (int i = 0; i < 4; i++) begin
            w.data = w.data << 8;
            if (pos < n) begin
               w.data[7:0] = group_bytes[pos];
               w.nbytes    = w.nbytes + 3'd1;
               pos++;
            end
         end
         answer_words.push_back(w);
      end
      byte_total = byte_total + 9'(n);
   endtask

   task automatic flush_label();
      if (label_len != 0) begin
         group_bytes[0] = 8'(label_len);
         for (int i = 0; i < label_len; i++)
            group_bytes[i + 1] = label_buf[i];
         queue_group(label_len + 1);
         label_len = 0;
      end
   endtask

   task automatic encode_char(input logic [7:0] ch, input logic last,
                              input logic [15:0] id, input logic [31:0] ip);
      packet_word_type w;
      if (!in_name) begin
         {group_bytes[0], group_bytes[1]}   = id;
         {group_bytes[2], group_bytes[3]}   = HDR_FLAGS;
         {group_bytes[4], group_bytes[5]}   = HDR_ONE;
         {group_bytes[6], group_bytes[7]}   = HDR_ONE;
         {group_bytes[8], group_bytes[9]}   = FIELD_ZERO;
         {group_bytes[10], group_bytes[11]} = FIELD_ZERO;
         in_name    = 1'b1;
         label_len  = 0;
         name_len   = 0;
         cut_seen   = 1'b0;
         byte_total = '0;
         queue_group(HDR_BYTES);
      end
      if (name_len < MAX_NAME_CHARS) begin
         name_len++;
         if (ch == DOT_CHAR) begin
            flush_label();
         end else if (label_len < MAX_LABEL_CHARS) begin
            label_buf[label_len] = ch;
            label_len++;
         end else begin
            cut_seen = 1'b1;
         end
      end else begin
         cut_seen = 1'b1;
      end
      if (last) begin
         flush_label();
         group_bytes[0] = 8'h00;
         {group_bytes[1], group_bytes[2]}   = HDR_ONE;
         {group_bytes[3], group_bytes[4]}   = HDR_ONE;
         {group_bytes[5], group_bytes[6]}   = ANS_POINTER;
         {group_bytes[7], group_bytes[8]}   = HDR_ONE;
         {group_bytes[9], group_bytes[10]}  = HDR_ONE;
         {group_bytes[11], group_bytes[12]} = FIELD_ZERO;
         {group_bytes[13], group_bytes[14]} = FIELD_ZERO;
         {group_bytes[15], group_bytes[16]} = ANS_RDLENGTH;
         {group_bytes[17], group_bytes[18], group_bytes[19], group_bytes[20]} = ip;
         queue_group(TAIL_BYTES);
         w       = answer_words.pop_back();
         w.last  = 1'b1;
         w.total = byte_total;
         w.cut   = cut_seen;
         answer_words.push_back(w);
         in_name    = 1'b0;
         label_len  = 0;
         name_len   = 0;
         cut_seen   = 1'b0;
         byte_total = '0;
      end
   endtask

   task automatic check_word();
      packet_word_type want;
      if (answer_words.size() == 0) begin
         report_mismatch("unexpected", '0, rsp_packet_word);
      end else begin
         want = answer_words.pop_front();
         if (rsp_packet_word !== want.data)
            report_mismatch("packet_word", want.data, rsp_packet_word);
         if (rsp_valid_bytes !== want.nbytes)
            report_mismatch("valid_bytes", 32'(want.nbytes), 32'(rsp_valid_bytes));
         if (rsp_packet_end !== want.last)
            report_mismatch("packet_end", 32'(want.last), 32'(rsp_packet_end));
         if (rsp_packet_length !== want.total)
            report_mismatch("packet_length", 32'(want.total), 32'(rsp_packet_length));
         if (rsp_truncated !== want.cut)
            report_mismatch("truncated", 32'(want.cut), 32'(rsp_truncated));
      end
      word_index++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         answer_words.delete();
         in_name    = 1'b0;
         label_len  = 0;
         name_len   = 0;
         cut_seen   = 1'b0;
         byte_total = '0;
         word_index = 0;
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall)
            encode_char(req_name_char, req_name_end, req_query_id, req_answer_ip);
         if (rsp_valid && !rsp_stall)
            check_word();
      end
      words_owed <= answer_words.size();
   end

endmodule

### test/dns_a_answer_builder_unit_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for dns_a_answer_builder_unit: clock, reset, name
// stimulus, response stalls and the verdict. Uses dnsab_pkg and the
// dnsab_answer_checker scoreboard.
module dns_a_answer_builder_unit_tb;
   import dnsab_pkg::*;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic [7:0]  req_name_char = '0;
   logic        req_name_end  = 1'b0;
   logic [15:0] req_query_id  = '0;
   logic [31:0] req_answer_ip = '0;
   logic        rsp_stall     = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [31:0] rsp_packet_word;
   logic [2:0]  rsp_valid_bytes;
   logic        rsp_packet_end;
   logic [8:0]  rsp_packet_length;
   logic        rsp_truncated;

   int          words_owed;
   int          fail_count;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          hold_len      = 0;
   int          hold_serial   = 0;
   int          hold_seen     = 0;
   int          hold_left     = 0;
   int          chars_sent    = 0;
   logic [7:0]  name_buf[$];

   dns_a_answer_builder_unit dut (.*);

   dnsab_answer_checker word_check (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (hold_serial != hold_seen) begin
         hold_seen <= hold_serial;
         hold_left <= hold_len;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic send_char(input logic [7:0] ch, input logic last,
                            input logic [15:0] id, input logic [31:0] ip);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_name_char <= ch;
      req_name_end  <= last;
      req_query_id  <= id;
      req_answer_ip <= ip;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   task automatic send_name(input logic [15:0] id, input logic [31:0] ip);
      int last_pos;
      last_pos = name_buf.size() - 1;
      for (int i = 0; i <= last_pos; i++)
         send_char(name_buf[i], i == last_pos, (i == 0) ? id : 16'($urandom),
                   (i == last_pos) ? ip : $urandom);
      name_buf.delete();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         name_buf.push_back(s[i]);
   endtask

   task automatic add_label(input int len, input bit any_byte);
      logic [7:0] c;
      repeat (len) begin
         if (any_byte) begin
            do c = 8'($urandom); while (c == DOT_CHAR);
         end else begin
            c = 8'($urandom_range(8'h7A, 8'h61));
         end
         name_buf.push_back(c);
      end
   endtask

   task automatic make_random_name();
      int kind;
      kind = $urandom_range(99);
      if (kind < 65) begin
         if ($urandom_range(9) == 0) name_buf.push_back(DOT_CHAR);
         for (int n = $urandom_range(4, 1); n > 0; n--) begin
            add_label($urandom_range(10, 1), $urandom_range(3) == 0);
            if (n > 1) name_buf.push_back(DOT_CHAR);
         end
         if ($urandom_range(9) == 0) name_buf.push_back(DOT_CHAR);
      end else if (kind < 85) begin
         repeat ($urandom_range(12, 1))
            name_buf.push_back(($urandom_range(3) == 0) ? DOT_CHAR : 8'($urandom));
      end else if (kind < 93) begin
         repeat ($urandom_range(5, 2)) begin
            repeat ($urandom_range(3)) name_buf.push_back(DOT_CHAR);
            add_label($urandom_range(3), 1'b1);
         end
      end else begin
         add_label($urandom_range(70, 62), 1'b1);
         name_buf.push_back(DOT_CHAR);
         add_label($urandom_range(5, 1), 1'b0);
      end
      if (name_buf.size() == 0) name_buf.push_back(DOT_CHAR);
   endtask

   task automatic run_random(input int count);
      int start;
      start = chars_sent;
      while (chars_sent - start < count) begin
         make_random_name();
         send_name(16'($urandom), $urandom);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_text("a");
      send_name(16'h0000, 32'h0000_0000);
      name_buf.push_back(8'h00);
      name_buf.push_back(8'hFF);
      send_name(16'hFFFF, 32'hFFFF_FFFF);
      add_text(".");
      send_name(16'h8001, 32'h0A00_0001);
      add_text(".a..bc.");
      send_name(16'h5A5A, 32'hC0A8_0101);
      add_text("ab.cde");
      send_name(16'h1234, 32'h7F00_0001);
      add_text("..");
      send_name(16'hA5A5, 32'h0102_0304);
      wait_drained();

      // The response side is held off while a name longer than the greatest length
      // is sent; the dot after its fourth label falls beyond the limit.
      hold_len = 300;
      hold_serial++;
      repeat (4) begin
         add_label(MAX_LABEL_CHARS, 1'b1);
         name_buf.push_back(DOT_CHAR);
      end
      add_text("xy");
      send_name(16'($urandom), $urandom);
      wait_drained();

      send_idle_pct = 61;
      rsp_stall_pct = 0;
      run_random(30);
      wait_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 61;
      run_random(30);
      wait_drained();
      send_idle_pct = 12;
      rsp_stall_pct = 12;
      run_random(30);
      wait_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random(30);

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && words_owed == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

### sim.f
hdl/dnsab_pkg.sv
hdl/dnsab_label_ram.sv
hdl/dnsab_word_format.sv
hdl/dns_a_answer_builder_unit.sv
test/dnsab_answer_checker.sv
test/dns_a_answer_builder_unit_tb.sv
